// File: design/sm83_pkg.sv
package sm83_pkg;

    // Command codes on the request channel
    localparam logic CMD_EXECUTE  = 1'b0;
    localparam logic CMD_READ_RSP = 1'b1;

    // Memory request codes
    localparam logic [1:0] MEM_NONE  = 2'd0;
    localparam logic [1:0] MEM_READ  = 2'd1;
    localparam logic [1:0] MEM_WRITE = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_INVALID    = 2'd1;
    localparam logic [1:0] ST_UNIMPL     = 2'd2;
    localparam logic [1:0] ST_STRAY_READ = 2'd3;

    // Implemented opcodes
    localparam logic [7:0] OPC_NOP     = 8'h00;
    localparam logic [7:0] OPC_LD_BC_A = 8'h02;
    localparam logic [7:0] OPC_JR      = 8'h18;
    localparam logic [7:0] OPC_JR_Z    = 8'h28;
    localparam logic [7:0] OPC_LD_A_N  = 8'h3E;
    localparam logic [7:0] OPC_LD_B_A  = 8'h47;
    localparam logic [7:0] OPC_XOR_A   = 8'hAF;
    localparam logic [7:0] OPC_JP      = 8'hC3;
    localparam logic [7:0] OPC_CALL    = 8'hCD;
    localparam logic [7:0] OPC_LDH_N_A = 8'hE0;
    localparam logic [7:0] OPC_LD_NN_A = 8'hEA;
    localparam logic [7:0] OPC_LDH_A_N = 8'hF0;
    localparam logic [7:0] OPC_DI      = 8'hF3;
    localparam logic [7:0] OPC_CP_N    = 8'hFE;

    // Opcodes that do not exist on the SM83
    localparam logic [7:0] OPC_ILL_D3 = 8'hD3;
    localparam logic [7:0] OPC_ILL_DB = 8'hDB;
    localparam logic [7:0] OPC_ILL_DD = 8'hDD;
    localparam logic [7:0] OPC_ILL_E3 = 8'hE3;
    localparam logic [7:0] OPC_ILL_E4 = 8'hE4;
    localparam logic [7:0] OPC_ILL_EB = 8'hEB;
    localparam logic [7:0] OPC_ILL_EC = 8'hEC;
    localparam logic [7:0] OPC_ILL_ED = 8'hED;
    localparam logic [7:0] OPC_ILL_F4 = 8'hF4;
    localparam logic [7:0] OPC_ILL_FC = 8'hFC;
    localparam logic [7:0] OPC_ILL_FD = 8'hFD;

    // Flag bit positions in the ZNHC nibble
    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    localparam logic [15:0] IO_PAGE = 16'hFF00;

    // Post-boot register values
    localparam logic [15:0] RESET_PC    = 16'h0100;
    localparam logic [15:0] RESET_SP    = 16'hFFFE;
    localparam logic [7:0]  RESET_A     = 8'h01;
    localparam logic [15:0] RESET_BC    = 16'h0013;
    localparam logic [3:0]  RESET_FLAGS = 4'h0;
    localparam logic        RESET_IE    = 1'b1;

    // Architectural state that affects results
    typedef struct packed {
        logic [15:0] pc;
        logic [15:0] sp;
        logic [7:0]  a;
        logic [15:0] bc;
        logic [3:0]  flags;
        logic        ie;
        logic        load_pending;
    } arch_state_t;

    // One result item
    typedef struct packed {
        logic [1:0]  mem_op;
        logic [15:0] mem_address;
        logic [7:0]  mem_write_data;
        logic [15:0] next_pc;
        logic [7:0]  accumulator;
        logic [3:0]  flag_bits;
        logic        irq_enabled;
        logic [1:0]  status;
        logic [2:0]  cycles_used;
        logic        last;
    } result_t;

endpackage

// File: design/sm83_decode.sv
module sm83_decode (
    input  sm83_pkg::arch_state_t st,
    input  logic                  command,
    input  logic [7:0]            opcode,
    input  logic [7:0]            imm_low,
    input  logic [7:0]            imm_high,
    input  logic [7:0]            read_data,
    output sm83_pkg::arch_state_t st_next,
    output sm83_pkg::result_t     res_first,
    output sm83_pkg::result_t     res_second,
    output logic                  two_results
);

    logic [15:0] imm16;
    logic [15:0] jr_target;
    logic [15:0] ret_addr;
    logic [15:0] sp_dec;
    logic [1:0]  op;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic [1:0]  status;
    logic [2:0]  cyc;

    assign imm16     = {imm_high, imm_low};
    assign jr_target = st.pc + 16'd2 + {{8{imm_low[7]}}, imm_low};
    assign ret_addr  = st.pc + 16'd3;
    assign sp_dec    = st.sp - 16'd2;

    // Decode and execute one request
    always_comb begin
        st_next     = st;
        op          = sm83_pkg::MEM_NONE;
        addr        = '0;
        wdata       = '0;
        status      = sm83_pkg::ST_OK;
        cyc         = 3'd0;
        two_results = 1'b0;

        if (command == sm83_pkg::CMD_READ_RSP) begin
            if (st.load_pending) begin
                st_next.a            = read_data;
                st_next.load_pending = 1'b0;
            end else begin
                status = sm83_pkg::ST_STRAY_READ;
            end
        end else begin
            unique case (opcode) inside
                sm83_pkg::OPC_NOP: begin
                    st_next.pc = st.pc + 16'd1;
                    cyc        = 3'd1;
                end
                sm83_pkg::OPC_LD_BC_A: begin
                    op         = sm83_pkg::MEM_WRITE;
                    addr       = st.bc;
                    wdata      = st.a;
                    st_next.pc = st.pc + 16'd1;
                    cyc        = 3'd2;
                end
                sm83_pkg::OPC_JR: begin
                    st_next.pc = jr_target;
                    cyc        = 3'd3;
                end
                sm83_pkg::OPC_JR_Z: begin
                    if (st.flags[sm83_pkg::FLAG_Z]) begin
                        st_next.pc = jr_target;
                        cyc        = 3'd3;
                    end else begin
                        st_next.pc = st.pc + 16'd2;
                        cyc        = 3'd2;
                    end
                end
                sm83_pkg::OPC_LD_A_N: begin
                    st_next.a  = imm_low;
                    st_next.pc = st.pc + 16'd2;
                    cyc        = 3'd2;
                end
                sm83_pkg::OPC_LD_B_A: begin
                    st_next.bc = {st.a, st.bc[7:0]};
                    st_next.pc = st.pc + 16'd1;
                    cyc        = 3'd1;
                end
                sm83_pkg::OPC_XOR_A: begin
                    st_next.a     = '0;
                    st_next.flags = 4'b1000;
                    st_next.pc    = st.pc + 16'd1;
                    cyc           = 3'd1;
                end
                sm83_pkg::OPC_JP: begin
                    st_next.pc = imm16;
                    cyc        = 3'd4;
                end
                sm83_pkg::OPC_CALL: begin
                    // Push return address as two byte writes, low byte first
                    op          = sm83_pkg::MEM_WRITE;
                    addr        = sp_dec;
                    wdata       = ret_addr[7:0];
                    st_next.sp  = sp_dec;
                    st_next.pc  = imm16;
                    two_results = 1'b1;
                end
                sm83_pkg::OPC_ILL_D3, sm83_pkg::OPC_ILL_DB, sm83_pkg::OPC_ILL_DD,
                sm83_pkg::OPC_ILL_E3, sm83_pkg::OPC_ILL_E4, sm83_pkg::OPC_ILL_EB,
                sm83_pkg::OPC_ILL_EC, sm83_pkg::OPC_ILL_ED, sm83_pkg::OPC_ILL_F4,
                sm83_pkg::OPC_ILL_FC, sm83_pkg::OPC_ILL_FD: begin
                    status = sm83_pkg::ST_INVALID;
                end
                sm83_pkg::OPC_LDH_N_A: begin
                    op         = sm83_pkg::MEM_WRITE;
                    addr       = sm83_pkg::IO_PAGE | {8'h00, imm_low};
                    wdata      = st.a;
                    st_next.pc = st.pc + 16'd2;
                    cyc        = 3'd3;
                end
                sm83_pkg::OPC_LD_NN_A: begin
                    op         = sm83_pkg::MEM_WRITE;
                    addr       = imm16;
                    wdata      = st.a;
                    st_next.pc = st.pc + 16'd3;
                    cyc        = 3'd4;
                end
                sm83_pkg::OPC_LDH_A_N: begin
                    op                   = sm83_pkg::MEM_READ;
                    addr                 = sm83_pkg::IO_PAGE | {8'h00, imm_low};
                    st_next.load_pending = 1'b1;
                    st_next.pc           = st.pc + 16'd2;
                    cyc                  = 3'd3;
                end
                sm83_pkg::OPC_DI: begin
                    st_next.ie = 1'b0;
                    st_next.pc = st.pc + 16'd1;
                    cyc        = 3'd1;
                end
                sm83_pkg::OPC_CP_N: begin
                    st_next.flags[sm83_pkg::FLAG_Z] = (st.a == imm_low);
                    st_next.flags[sm83_pkg::FLAG_N] = 1'b1;
                    st_next.flags[sm83_pkg::FLAG_H] = (st.a[3:0] < imm_low[3:0]);
                    st_next.flags[sm83_pkg::FLAG_C] = (st.a < imm_low);
                    st_next.pc = st.pc + 16'd2;
                    cyc        = 3'd2;
                end
                default: begin
                    status     = sm83_pkg::ST_UNIMPL;
                    st_next.pc = st.pc + 16'd1;
                end
            endcase
        end
    end

    // Build result items from the updated state
    always_comb begin
        res_first.mem_op         = op;
        res_first.mem_address    = addr;
        res_first.mem_write_data = wdata;
        res_first.next_pc        = st_next.pc;
        res_first.accumulator    = st_next.a;
        res_first.flag_bits      = st_next.flags;
        res_first.irq_enabled    = st_next.ie;
        res_first.status         = status;
        res_first.cycles_used    = cyc;
        res_first.last           = !two_results;

        res_second                = res_first;
        res_second.mem_address    = sp_dec + 16'd1;
        res_second.mem_write_data = ret_addr[15:8];
        res_second.cycles_used    = 3'd6;
        res_second.last           = 1'b1;
    end

endmodule

// File: design/sm83_subset_instruction_executor.sv
// Each result is registered into the result buffer before it appears on the m_ side.
// Throughput: one request per cycle while m_ready keeps the buffer drained; a call yields
// two results and holds s_ready low while the three-entry result buffer drains.
// Reset: synchronous active-low aresetn loads the post-boot register values and
// empties the result buffer.
module sm83_subset_instruction_executor (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_command,
    input  logic [7:0]  s_opcode,
    input  logic [7:0]  s_imm_low,
    input  logic [7:0]  s_imm_high,
    input  logic [7:0]  s_read_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_mem_op,
    output logic [15:0] m_mem_address,
    output logic [7:0]  m_mem_write_data,
    output logic [15:0] m_next_pc,
    output logic [7:0]  m_accumulator,
    output logic [3:0]  m_flag_bits,
    output logic        m_irq_enabled,
    output logic [1:0]  m_status,
    output logic [2:0]  m_cycles_used,
    output logic        m_last
);

    sm83_pkg::arch_state_t state_reg;
    sm83_pkg::arch_state_t state_next;
    sm83_pkg::result_t     res_first;
    sm83_pkg::result_t     res_second;
    logic                  two_results;

    sm83_pkg::result_t     slot_reg  [3];
    sm83_pkg::result_t     slot_next [3];
    logic [1:0]            count_reg;
    logic [1:0]            count_next;
    logic [1:0]            count_kept;
    logic                  push;
    logic                  pop;

    sm83_decode u_decode (
        .st          (state_reg),
        .command     (s_command),
        .opcode      (s_opcode),
        .imm_low     (s_imm_low),
        .imm_high    (s_imm_high),
        .read_data   (s_read_data),
        .st_next     (state_next),
        .res_first   (res_first),
        .res_second  (res_second),
        .two_results (two_results)
    );

    // Accept while room for two results remains
    assign s_ready = (count_reg <= 2'd1);
    assign m_valid = (count_reg != 2'd0);
    assign push    = s_valid && s_ready;
    assign pop     = m_valid && m_ready;

    // Advance the architectural state on each accepted request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.pc           <= sm83_pkg::RESET_PC;
            state_reg.sp           <= sm83_pkg::RESET_SP;
            state_reg.a            <= sm83_pkg::RESET_A;
            state_reg.bc           <= sm83_pkg::RESET_BC;
            state_reg.flags        <= sm83_pkg::RESET_FLAGS;
            state_reg.ie           <= sm83_pkg::RESET_IE;
            state_reg.load_pending <= 1'b0;
        end else if (push) begin
            state_reg <= state_next;
        end
    end

    // Shift out the head on pop, append new results behind the kept ones
    always_comb begin
        slot_next[0] = slot_reg[0];
        slot_next[1] = slot_reg[1];
        slot_next[2] = slot_reg[2];
        if (pop) begin
            slot_next[0] = slot_reg[1];
            slot_next[1] = slot_reg[2];
        end
        count_kept = count_reg - {1'b0, pop};
        count_next = count_kept;
        if (push) begin
            if (count_kept == 2'd0) begin
                slot_next[0] = res_first;
                slot_next[1] = res_second;
            end else begin
                slot_next[1] = res_first;
                slot_next[2] = res_second;
            end
            count_next = count_kept + (two_results ? 2'd2 : 2'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Hold result payloads
    always_ff @(posedge aclk) begin
        slot_reg[0] <= slot_next[0];
        slot_reg[1] <= slot_next[1];
        slot_reg[2] <= slot_next[2];
    end

    assign m_mem_op         = slot_reg[0].mem_op;
    assign m_mem_address    = slot_reg[0].mem_address;
    assign m_mem_write_data = slot_reg[0].mem_write_data;
    assign m_next_pc        = slot_reg[0].next_pc;
    assign m_accumulator    = slot_reg[0].accumulator;
    assign m_flag_bits      = slot_reg[0].flag_bits;
    assign m_irq_enabled    = slot_reg[0].irq_enabled;
    assign m_status         = slot_reg[0].status;
    assign m_cycles_used    = slot_reg[0].cycles_used;
    assign m_last           = slot_reg[0].last;

endmodule

// File: bench/sm83_subset_instruction_executor_test.sv
`timescale 1ns / 100ps

module sm83_subset_instruction_executor_test;

    localparam logic [7:0] OPC_PREFIX_CB = 8'hCB;
    localparam int unsigned RANDOM_ITEMS = 1900;
    localparam int unsigned REPORT_LIMIT = 10;

    // One request on the s_ side
    typedef struct packed {
        logic       command;
        logic [7:0] opcode;
        logic [7:0] imm_low;
        logic [7:0] imm_high;
        logic [7:0] read_data;
    } cpu_item_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_command = sm83_pkg::CMD_EXECUTE;
    logic [7:0]  s_opcode = 8'h00;
    logic [7:0]  s_imm_low = 8'h00;
    logic [7:0]  s_imm_high = 8'h00;
    logic [7:0]  s_read_data = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_mem_op;
    logic [15:0] m_mem_address;
    logic [7:0]  m_mem_write_data;
    logic [15:0] m_next_pc;
    logic [7:0]  m_accumulator;
    logic [3:0]  m_flag_bits;
    logic        m_irq_enabled;
    logic [1:0]  m_status;
    logic [2:0]  m_cycles_used;
    logic        m_last;

    sm83_subset_instruction_executor dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_opcode         (s_opcode),
        .s_imm_low        (s_imm_low),
        .s_imm_high       (s_imm_high),
        .s_read_data      (s_read_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_mem_op         (m_mem_op),
        .m_mem_address    (m_mem_address),
        .m_mem_write_data (m_mem_write_data),
        .m_next_pc        (m_next_pc),
        .m_accumulator    (m_accumulator),
        .m_flag_bits      (m_flag_bits),
        .m_irq_enabled    (m_irq_enabled),
        .m_status         (m_status),
        .m_cycles_used    (m_cycles_used),
        .m_last           (m_last)
    );

    // Program to feed and results still owed by the block
    cpu_item_t           program_items[$];
    sm83_pkg::result_t   results_due[$];
    cpu_item_t           offered;
    int unsigned program_total = 0;
    int unsigned accepted_count = 0;
    int unsigned checked_count = 0;
    int unsigned bad_results = 0;
    int unsigned send_idle = 0;
    int unsigned recv_idle = 0;
    logic        hold_off = 1'b0;

    // Shadow CPU state
    logic [15:0] cpu_pc;
    logic [15:0] cpu_sp;
    logic [7:0]  cpu_a;
    logic [15:0] cpu_bc;
    logic [3:0]  cpu_flags;
    logic        cpu_ie;
    logic        read_outstanding;
    longint unsigned machine_cycles = 0;
    int unsigned calls_run = 0;
    int unsigned loads_answered = 0;
    int unsigned stray_responses = 0;

    function automatic void reset_shadow_cpu();
        cpu_pc = sm83_pkg::RESET_PC;
        cpu_sp = sm83_pkg::RESET_SP;
        cpu_a = sm83_pkg::RESET_A;
        cpu_bc = sm83_pkg::RESET_BC;
        cpu_flags = sm83_pkg::RESET_FLAGS;
        cpu_ie = sm83_pkg::RESET_IE;
        read_outstanding = 1'b0;
    endfunction

    function automatic sm83_pkg::result_t snapshot(input logic [1:0] op,
                                                   input logic [15:0] addr,
                                                   input logic [7:0] wdata,
                                                   input logic [1:0] st,
                                                   input logic [2:0] cyc, input logic fin);
        sm83_pkg::result_t r;
        r.mem_op = op;
        r.mem_address = addr;
        r.mem_write_data = wdata;
        r.next_pc = cpu_pc;
        r.accumulator = cpu_a;
        r.flag_bits = cpu_flags;
        r.irq_enabled = cpu_ie;
        r.status = st;
        r.cycles_used = cyc;
        r.last = fin;
        return r;
    endfunction

    // Execute one accepted request on the shadow CPU and queue what it owes
    task automatic run_instruction(input cpu_item_t it);
        logic [1:0]  op;
        logic [15:0] addr;
        logic [7:0]  wdata;
        logic [1:0]  st;
        logic [2:0]  cyc;
        logic [15:0] next;
        logic [15:0] offset;
        logic [15:0] imm16;
        logic [15:0] ret_addr;
        op = sm83_pkg::MEM_NONE;
        addr = 16'h0000;
        wdata = 8'h00;
        st = sm83_pkg::ST_OK;
        cyc = 3'd0;
        next = cpu_pc;
        offset = {{8{it.imm_low[7]}}, it.imm_low};
        imm16 = {it.imm_high, it.imm_low};
        ret_addr = cpu_pc + 16'd3;
        if (it.command == sm83_pkg::CMD_READ_RSP) begin
            if (read_outstanding) begin
                cpu_a = it.read_data;
                read_outstanding = 1'b0;
                loads_answered++;
            end else begin
                st = sm83_pkg::ST_STRAY_READ;
                stray_responses++;
            end
            results_due.push_back(snapshot(op, addr, wdata, st, cyc, 1'b1));
        end else begin
            case (it.opcode)
                sm83_pkg::OPC_NOP: begin
                    next = cpu_pc + 16'd1;
                    cyc = 3'd1;
                end
                sm83_pkg::OPC_LD_BC_A: begin
                    op = sm83_pkg::MEM_WRITE;
                    addr = cpu_bc;
                    wdata = cpu_a;
                    next = cpu_pc + 16'd1;
                    cyc = 3'd2;
                end
                sm83_pkg::OPC_JR: begin
                    next = cpu_pc + 16'd2 + offset;
                    cyc = 3'd3;
                end
                sm83_pkg::OPC_JR_Z: begin
                    if (cpu_flags[sm83_pkg::FLAG_Z]) begin
                        next = cpu_pc + 16'd2 + offset;
                        cyc = 3'd3;
                    end else begin
                        next = cpu_pc + 16'd2;
                        cyc = 3'd2;
                    end
                end
                sm83_pkg::OPC_LD_A_N: begin
                    cpu_a = it.imm_low;
                    next = cpu_pc + 16'd2;
                    cyc = 3'd2;
                end
                sm83_pkg::OPC_LD_B_A: begin
                    cpu_bc = {cpu_a, cpu_bc[7:0]};
                    next = cpu_pc + 16'd1;
                    cyc = 3'd1;
                end
                sm83_pkg::OPC_XOR_A: begin
                    cpu_a = 8'h00;
                    cpu_flags = 4'b0000;
                    cpu_flags[sm83_pkg::FLAG_Z] = 1'b1;
                    next = cpu_pc + 16'd1;
                    cyc = 3'd1;
                end
                sm83_pkg::OPC_JP: begin
                    next = imm16;
                    cyc = 3'd4;
                end
                sm83_pkg::OPC_CALL: begin
                    cpu_sp = cpu_sp - 16'd2;
                    next = imm16;
                    cyc = 3'd6;
                    calls_run++;
                end
                sm83_pkg::OPC_ILL_D3, sm83_pkg::OPC_ILL_DB, sm83_pkg::OPC_ILL_DD,
                sm83_pkg::OPC_ILL_E3, sm83_pkg::OPC_ILL_E4, sm83_pkg::OPC_ILL_EB,
                sm83_pkg::OPC_ILL_EC, sm83_pkg::OPC_ILL_ED, sm83_pkg::OPC_ILL_F4,
                sm83_pkg::OPC_ILL_FC, sm83_pkg::OPC_ILL_FD: begin
                    st = sm83_pkg::ST_INVALID;
                end
                sm83_pkg::OPC_LDH_N_A: begin
                    op = sm83_pkg::MEM_WRITE;
                    addr = sm83_pkg::IO_PAGE + {8'h00, it.imm_low};
                    wdata = cpu_a;
                    next = cpu_pc + 16'd2;
                    cyc = 3'd3;
                end
                sm83_pkg::OPC_LD_NN_A: begin
                    op = sm83_pkg::MEM_WRITE;
                    addr = imm16;
                    wdata = cpu_a;
                    next = cpu_pc + 16'd3;
                    cyc = 3'd4;
                end
                sm83_pkg::OPC_LDH_A_N: begin
                    op = sm83_pkg::MEM_READ;
                    addr = sm83_pkg::IO_PAGE + {8'h00, it.imm_low};
                    read_outstanding = 1'b1;
                    next = cpu_pc + 16'd2;
                    cyc = 3'd3;
                end
                sm83_pkg::OPC_DI: begin
                    cpu_ie = 1'b0;
                    next = cpu_pc + 16'd1;
                    cyc = 3'd1;
                end
                sm83_pkg::OPC_CP_N: begin
                    cpu_flags = 4'b0000;
                    cpu_flags[sm83_pkg::FLAG_N] = 1'b1;
                    cpu_flags[sm83_pkg::FLAG_Z] = (cpu_a == it.imm_low);
                    cpu_flags[sm83_pkg::FLAG_H] = (cpu_a[3:0] < it.imm_low[3:0]);
                    cpu_flags[sm83_pkg::FLAG_C] = (cpu_a < it.imm_low);
                    next = cpu_pc + 16'd2;
                    cyc = 3'd2;
                end
                default: begin
                    st = sm83_pkg::ST_UNIMPL;
                    next = cpu_pc + 16'd1;
                end
            endcase
            cpu_pc = next;
            machine_cycles += cyc;
            // A call pushes the return address low byte first, then high byte
            if (it.opcode == sm83_pkg::OPC_CALL) begin
                results_due.push_back(snapshot(sm83_pkg::MEM_WRITE, cpu_sp, ret_addr[7:0],
                                               sm83_pkg::ST_OK, 3'd0, 1'b0));
                results_due.push_back(snapshot(sm83_pkg::MEM_WRITE, cpu_sp + 16'd1,
                                               ret_addr[15:8], sm83_pkg::ST_OK, cyc, 1'b1));
            end else begin
                results_due.push_back(snapshot(op, addr, wdata, st, cyc, 1'b1));
            end
        end
    endtask

    function automatic void add_exec(input logic [7:0] opc, input logic [7:0] lo,
                                     input logic [7:0] hi);
        cpu_item_t it;
        it.command = sm83_pkg::CMD_EXECUTE;
        it.opcode = opc;
        it.imm_low = lo;
        it.imm_high = hi;
        it.read_data = 8'($urandom);
        program_items.push_back(it);
    endfunction

    function automatic void add_response(input logic [7:0] rdata);
        cpu_item_t it;
        it.command = sm83_pkg::CMD_READ_RSP;
        it.opcode = 8'($urandom);
        it.imm_low = 8'($urandom);
        it.imm_high = 8'($urandom);
        it.read_data = rdata;
        program_items.push_back(it);
    endfunction

    function automatic logic [7:0] pick_supported();
        case ($urandom_range(0, 13))
            0:       return sm83_pkg::OPC_NOP;
            1:       return sm83_pkg::OPC_LD_BC_A;
            2:       return sm83_pkg::OPC_JR;
            3:       return sm83_pkg::OPC_JR_Z;
            4:       return sm83_pkg::OPC_LD_A_N;
            5:       return sm83_pkg::OPC_LD_B_A;
            6:       return sm83_pkg::OPC_XOR_A;
            7:       return sm83_pkg::OPC_JP;
            8:       return sm83_pkg::OPC_CALL;
            9:       return sm83_pkg::OPC_LDH_N_A;
            10:      return sm83_pkg::OPC_LD_NN_A;
            11:      return sm83_pkg::OPC_LDH_A_N;
            12:      return sm83_pkg::OPC_DI;
            default: return sm83_pkg::OPC_CP_N;
        endcase
    endfunction

    function automatic logic [7:0] pick_illegal();
        case ($urandom_range(0, 10))
            0:       return sm83_pkg::OPC_ILL_D3;
            1:       return sm83_pkg::OPC_ILL_DB;
            2:       return sm83_pkg::OPC_ILL_DD;
            3:       return sm83_pkg::OPC_ILL_E3;
            4:       return sm83_pkg::OPC_ILL_E4;
            5:       return sm83_pkg::OPC_ILL_EB;
            6:       return sm83_pkg::OPC_ILL_EC;
            7:       return sm83_pkg::OPC_ILL_ED;
            8:       return sm83_pkg::OPC_ILL_F4;
            9:       return sm83_pkg::OPC_ILL_FC;
            default: return sm83_pkg::OPC_ILL_FD;
        endcase
    endfunction

    // Mostly no gap, some short ones, a few long; none at all inside calm windows
    function automatic int unsigned idle_cycles(input bit calm);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 75) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    function automatic string describe(input sm83_pkg::result_t r);
        return $sformatf({"op %0d addr %h wdata %h pc %h a %h znhc %b ie %b ",
                          "status %0d cyc %0d last %b"},
                         r.mem_op, r.mem_address, r.mem_write_data, r.next_pc, r.accumulator,
                         r.flag_bits, r.irq_enabled, r.status, r.cycles_used, r.last);
    endfunction

    // Clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Request driver: predict on acceptance, then offer the next request
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                run_instruction(offered);
                accepted_count++;
            end
            if (s_valid && !s_ready) begin
                // hold the current request
            end else if (send_idle > 0) begin
                send_idle--;
                s_valid <= 1'b0;
            end else if (program_items.size() > 0) begin
                offered = program_items.pop_front();
                s_command <= offered.command;
                s_opcode <= offered.opcode;
                s_imm_low <= offered.imm_low;
                s_imm_high <= offered.imm_high;
                s_read_data <= offered.read_data;
                s_valid <= 1'b1;
                send_idle = hold_off ? 0 : idle_cycles(((accepted_count / 100) % 4) == 0);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result monitor: check against the oldest owed result, then pace m_ready
    always @(posedge aclk) begin
        sm83_pkg::result_t seen;
        sm83_pkg::result_t owed;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                seen.mem_op = m_mem_op;
                seen.mem_address = m_mem_address;
                seen.mem_write_data = m_mem_write_data;
                seen.next_pc = m_next_pc;
                seen.accumulator = m_accumulator;
                seen.flag_bits = m_flag_bits;
                seen.irq_enabled = m_irq_enabled;
                seen.status = m_status;
                seen.cycles_used = m_cycles_used;
                seen.last = m_last;
                checked_count++;
                if (results_due.size() == 0) begin
                    bad_results++;
                    if (bad_results <= REPORT_LIMIT)
                        $display("unexpected result %0d: %s", checked_count, describe(seen));
                end else begin
                    owed = results_due.pop_front();
                    if (seen !== owed) begin
                        bad_results++;
                        if (bad_results <= REPORT_LIMIT) begin
                            $display("result %0d mismatch, expected: %s", checked_count,
                                     describe(owed));
                            $display("result %0d mismatch, actual:   %s", checked_count,
                                     describe(seen));
                        end
                    end
                end
            end
            if (hold_off) begin
                m_ready <= 1'b0;
            end else if (recv_idle > 0) begin
                recv_idle--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                recv_idle = idle_cycles(((checked_count / 100) % 4) == 2);
            end
        end
    end

    // Long receiver stall while the sender keeps pushing requests
    initial begin
        while (accepted_count < 400) @(posedge aclk);
        hold_off <= 1'b1;
        repeat (200) @(posedge aclk);
        hold_off <= 1'b0;
    end

    // Overall time limit
    initial begin
        #15_000_000;
        $display("FAIL sm83_subset_instruction_executor");
        $finish;
    end

    // Build the program, run it, and report
    initial begin
        int unsigned roll;
        reset_shadow_cpu();

        // Directed: every opcode class, operand extremes, wraps and load handling
        add_exec(sm83_pkg::OPC_LD_BC_A, 8'h00, 8'h00);
        add_exec(sm83_pkg::OPC_LD_A_N, 8'hFF, 8'h00);
        add_exec(sm83_pkg::OPC_LD_B_A, 8'h00, 8'hFF);
        add_exec(sm83_pkg::OPC_LD_BC_A, 8'hFF, 8'hFF);
        add_exec(sm83_pkg::OPC_CP_N, 8'hFF, 8'h00);
        add_exec(sm83_pkg::OPC_CP_N, 8'h00, 8'h00);
        add_exec(sm83_pkg::OPC_LD_A_N, 8'h00, 8'hFF);
        add_exec(sm83_pkg::OPC_CP_N, 8'hFF, 8'hFF);
        add_exec(sm83_pkg::OPC_JR_Z, 8'h05, 8'h00);
        add_exec(sm83_pkg::OPC_XOR_A, 8'hFF, 8'hFF);
        add_exec(sm83_pkg::OPC_JR_Z, 8'h80, 8'h00);
        add_exec(sm83_pkg::OPC_JR, 8'h7F, 8'h00);
        add_exec(sm83_pkg::OPC_JP, 8'hFF, 8'hFF);
        add_exec(sm83_pkg::OPC_NOP, 8'h00, 8'h00);
        add_exec(sm83_pkg::OPC_JR, 8'h80, 8'hFF);
        add_exec(sm83_pkg::OPC_LDH_N_A, 8'hFF, 8'h00);
        add_exec(sm83_pkg::OPC_LD_NN_A, 8'h00, 8'h00);
        add_response(8'hAA);
        add_exec(sm83_pkg::OPC_LDH_A_N, 8'h00, 8'hFF);
        add_exec(sm83_pkg::OPC_CALL, 8'hFE, 8'hFF);
        add_exec(sm83_pkg::OPC_CALL, 8'h00, 8'h00);
        add_response(8'h55);
        add_exec(sm83_pkg::OPC_DI, 8'h00, 8'h00);
        add_exec(sm83_pkg::OPC_ILL_ED, 8'hFF, 8'hFF);
        add_exec(OPC_PREFIX_CB, 8'h00, 8'hFF);

        // Random: mostly supported instructions, load/response pairs, some noise
        while (program_items.size() < RANDOM_ITEMS + 25) begin
            roll = $urandom_range(0, 99);
            if (roll < 60) begin
                add_exec(pick_supported(), 8'($urandom), 8'($urandom));
            end else if (roll < 75) begin
                add_exec(sm83_pkg::OPC_LDH_A_N, 8'($urandom), 8'($urandom));
                repeat ($urandom_range(0, 2))
                    add_exec(pick_supported(), 8'($urandom), 8'($urandom));
                if ($urandom_range(0, 9) < 9) add_response(8'($urandom));
            end else if (roll < 80) begin
                add_exec(sm83_pkg::OPC_XOR_A, 8'($urandom), 8'($urandom));
                add_exec(sm83_pkg::OPC_JR_Z, 8'($urandom), 8'($urandom));
            end else if (roll < 90) begin
                add_exec(8'($urandom_range(0, 255)), 8'($urandom), 8'($urandom));
            end else if (roll < 95) begin
                add_exec(pick_illegal(), 8'($urandom), 8'($urandom));
            end else begin
                add_response(8'($urandom));
            end
        end
        program_total = program_items.size();

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Drain: all requests taken, all results back, then a short settle
        while (accepted_count < program_total) @(posedge aclk);
        while (results_due.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (results_due.size() != 0) bad_results++;

        $display("ran %0d requests (%0d calls, %0d loads answered, %0d stray responses)",
                 accepted_count, calls_run, loads_answered, stray_responses);
        $display("checked %0d results over %0d machine cycles, %0d bad",
                 checked_count, machine_cycles, bad_results);
        if (bad_results == 0) begin
            $display("PASS sm83_subset_instruction_executor");
        end else begin
            $display("FAIL sm83_subset_instruction_executor");
        end
        $finish;
    end

endmodule

// File: sm83_subset_instruction_executor.f
design/sm83_pkg.sv
design/sm83_decode.sv
design/sm83_subset_instruction_executor.sv
bench/sm83_subset_instruction_executor_test.sv
